// ===== sv/gbn_pkg.sv =====
// Shared types and constants of the go-back-n sender window.
`default_nettype none
package gbn_pkg;

   localparam int SEQ_W        = 8;
   localparam int BUFFER_SLOTS = 256;
   localparam int SLOT_W       = $clog2(BUFFER_SLOTS);
   localparam int WINDOW_MAX   = 63;
   localparam int LIMIT_W      = 6;
   localparam int QLEN_W       = 10;
   localparam int CSR_W        = 10;

   localparam logic [LIMIT_W-1:0] WINDOW_LIMIT_RST    = 6'd63;
   localparam logic [QLEN_W-1:0]  QUEUE_THRESHOLD_RST = 10'd50;

   // request kinds
   localparam logic [2:0] EV_NEW_PKT   = 3'd0;
   localparam logic [2:0] EV_PHY_READY = 3'd1;
   localparam logic [2:0] EV_FRAME_RX  = 3'd2;
   localparam logic [2:0] EV_DATA_TO   = 3'd3;
   localparam logic [2:0] EV_ACK_TO    = 3'd4;

   // data timer commands
   localparam logic [1:0] DCMD_NONE    = 2'd0;
   localparam logic [1:0] DCMD_STOP    = 2'd1;
   localparam logic [1:0] DCMD_RESTART = 2'd2;

   // ack timer commands
   localparam logic [1:0] ACMD_NONE  = 2'd0;
   localparam logic [1:0] ACMD_START = 2'd1;
   localparam logic [1:0] ACMD_STOP  = 2'd2;

   // frame kinds
   localparam logic FRAME_DATA = 1'b0;
   localparam logic FRAME_ACK  = 1'b1;

   // config register indexes
   localparam logic CSR_WINDOW_LIMIT    = 1'b0;
   localparam logic CSR_QUEUE_THRESHOLD = 1'b1;

   typedef struct packed {
      logic [SEQ_W-1:0] a;
      logic [SEQ_W-1:0] b;
      logic [SEQ_W:0]   bound;
   } dist_req_type;

   typedef struct packed {
      logic [SEQ_W-1:0] diff;
      logic             below;
   } dist_rsp_type;

   typedef struct packed {
      logic [SEQ_W-1:0] ack;
      logic [SEQ_W-1:0] handle;
   } slot_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      slot_type          wr_data;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
   } store_cmd_type;

   typedef struct packed {
      logic             pad;
      logic             network_enable;
      logic [1:0]       ack_timer_cmd;
      logic [1:0]       data_timer_cmd;
      logic             accepted;
      logic [SEQ_W-1:0] frame_handle;
      logic [SEQ_W-1:0] frame_ack;
      logic [SEQ_W-1:0] frame_seq;
      logic             frame_valid;
   } rsp_fields_type;

endpackage
`default_nettype wire

// ===== sv/go_back_n_sender_window.sv =====
// Go-back-n sender window: event sequencer, window state and result register.
//
// Each request transaction carries one event. A sequencer runs it through one
// shared distance/compare unit: events step through the outstanding-count,
// ack (received frames only), apply, final and emit states. A data timeout
// with outstanding frames reads the store and resends once per frame, via the
// shared unit and the registered read port of the 256-slot handle store.
// Results sit in an output register, so a stalled rsp side only delays the
// sequencer at its emit and resend steps. Store slots are valid only once sent.
`default_nettype none
module go_back_n_sender_window
   import gbn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_tvalid,
   output logic              req_tready,
   // packet_handle, rx_ack, rx_has_data, local_expected, phy_queue_len, zero fill
   input  logic [39:0]       req_tdata,
   // req_type
   input  logic [2:0]        req_tuser,

   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // frame_valid, frame_seq, frame_ack, frame_handle, accepted,
   // data_timer_cmd, ack_timer_cmd, network_enable, zero fill
   output logic [31:0]       rsp_tdata,
   // frame_kind
   output logic              rsp_tuser,
   output logic              rsp_tlast,

   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_OUTST   = 3'd1;
   localparam logic [2:0] ST_ACK     = 3'd2;
   localparam logic [2:0] ST_APPLY   = 3'd3;
   localparam logic [2:0] ST_FINAL   = 3'd4;
   localparam logic [2:0] ST_EMIT    = 3'd5;
   localparam logic [2:0] ST_RD      = 3'd6;
   localparam logic [2:0] ST_RESEND  = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic [QLEN_W-1:0]  thresh_ff;
   logic [SEQ_W-1:0]   base_ff, base_in;
   logic [SEQ_W-1:0]   next_ff, next_in;
   logic               phy_ff, phy_in;

   logic [2:0]         type_ff;
   logic [SEQ_W-1:0]   handle_ff, rxack_ff, lexp_ff;
   logic               hasdata_ff;
   logic [QLEN_W-1:0]  qlen_ff;

   logic [SEQ_W-1:0]   w_ff, w_in;
   logic               room_ff, room_in;
   logic               moved_ff, moved_in;
   logic               acc_ff, acc_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic               en_ff, en_in;
   logic               busy_ff, busy_in;
   logic [SEQ_W-1:0]   s_ff, s_in;
   logic [LIMIT_W-1:0] n_ff, n_in;
   logic               lastrs_ff, lastrs_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_fields_type     rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;
   logic               rsp_last_ff, rsp_last_in;

   dist_req_type       dreq;
   dist_rsp_type       drsp;
   store_cmd_type      scmd;
   slot_type           rd_slot;

   logic               req_fire, out_free, load_rsp;
   logic [1:0]         dcmd_done;

   gbn_dist_unit u_dist (
      .req (dreq),
      .rsp (drsp)
   );

   gbn_store u_store (
      .clock   (clock),
      .cmd     (scmd),
      .rd_data (rd_slot)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign dcmd_done  = busy_ff ? DCMD_RESTART : DCMD_STOP;

   always_comb begin
      dreq = '{a: next_ff, b: base_ff, bound: {3'b000, limit_ff}};
      case (state_ff)
         ST_ACK: dreq = '{a: rxack_ff, b: base_ff, bound: {1'b0, w_ff} + 9'd1};
         ST_RD:  dreq = '{a: next_ff, b: s_ff, bound: 9'd2};
         default: ;
      endcase
   end

   always_comb begin
      scmd.wr_en   = (state_ff == ST_APPLY) && (type_ff == EV_NEW_PKT) && room_ff;
      scmd.wr_addr = next_ff[SLOT_W-1:0];
      scmd.wr_data = '{ack: lexp_ff, handle: handle_ff};
      scmd.rd_en   = (state_ff == ST_RD);
      scmd.rd_addr = s_ff[SLOT_W-1:0];
   end

   always_comb begin
      state_in  = state_ff;
      base_in   = base_ff;
      next_in   = next_ff;
      phy_in    = phy_ff;
      w_in      = w_ff;
      room_in   = room_ff;
      moved_in  = moved_ff;
      acc_in    = acc_ff;
      seq_in    = seq_ff;
      en_in     = en_ff;
      busy_in   = busy_ff;
      s_in      = s_ff;
      n_in      = n_ff;
      lastrs_in = lastrs_ff;
      load_rsp  = 1'b0;
      rsp_data_in = '0;
      rsp_user_in = FRAME_DATA;
      rsp_last_in = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               moved_in = 1'b0;
               acc_in   = 1'b0;
               state_in = ST_OUTST;
            end
         end
         ST_OUTST: begin
            w_in     = drsp.diff;
            room_in  = drsp.below;
            state_in = (type_ff == EV_FRAME_RX) ? ST_ACK : ST_APPLY;
         end
         ST_ACK: begin
            if (drsp.diff != '0 && drsp.below) begin
               base_in  = rxack_ff;
               moved_in = 1'b1;
            end
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            case (type_ff)
               EV_NEW_PKT: begin
                  if (room_ff) begin
                     seq_in  = next_ff;
                     next_in = next_ff + 8'd1;
                     phy_in  = 1'b0;
                     acc_in  = 1'b1;
                  end
               end
               EV_PHY_READY:          phy_in = 1'b1;
               EV_DATA_TO, EV_ACK_TO: phy_in = 1'b0;
               default: ;
            endcase
            if (qlen_ff < thresh_ff) begin
               phy_in = 1'b1;
            end
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            en_in   = drsp.below && phy_ff;
            busy_in = (drsp.diff != '0);
            if (type_ff == EV_DATA_TO && drsp.diff != '0) begin
               s_in     = base_ff;
               n_in     = '0;
               state_in = ST_RD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_RD: begin
            lastrs_in = drsp.below || (n_ff == LIMIT_W'(WINDOW_MAX - 1));
            state_in  = ST_RESEND;
         end
         ST_RESEND: begin
            rsp_data_in.frame_valid    = 1'b1;
            rsp_data_in.frame_seq      = s_ff;
            rsp_data_in.frame_ack      = rd_slot.ack;
            rsp_data_in.frame_handle   = rd_slot.handle;
            rsp_data_in.data_timer_cmd = lastrs_ff ? dcmd_done : DCMD_NONE;
            rsp_data_in.network_enable = en_ff;
            rsp_last_in                = lastrs_ff;
            if (out_free) begin
               load_rsp = 1'b1;
               s_in     = s_ff + 8'd1;
               n_in     = n_ff + 6'd1;
               state_in = lastrs_ff ? ST_IDLE : ST_RD;
            end
         end
         ST_EMIT: begin
            rsp_data_in.network_enable = en_ff;
            case (type_ff)
               EV_NEW_PKT: begin
                  rsp_data_in.frame_valid  = acc_ff;
                  rsp_data_in.accepted     = acc_ff;
                  rsp_data_in.frame_seq    = acc_ff ? seq_ff : '0;
                  rsp_data_in.frame_ack    = acc_ff ? lexp_ff : '0;
                  rsp_data_in.frame_handle = acc_ff ? handle_ff : '0;
                  rsp_data_in.data_timer_cmd = acc_ff ? dcmd_done : DCMD_NONE;
               end
               EV_FRAME_RX: begin
                  rsp_data_in.data_timer_cmd = moved_ff ? dcmd_done : DCMD_NONE;
                  rsp_data_in.ack_timer_cmd  = hasdata_ff ? ACMD_START : ACMD_NONE;
               end
               EV_DATA_TO: rsp_data_in.data_timer_cmd = dcmd_done;
               EV_ACK_TO: begin
                  rsp_data_in.frame_valid   = 1'b1;
                  rsp_data_in.frame_ack     = lexp_ff;
                  rsp_data_in.ack_timer_cmd = ACMD_STOP;
                  rsp_user_in               = FRAME_ACK;
               end
               default: ;
            endcase
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= WINDOW_LIMIT_RST;
         thresh_ff    <= QUEUE_THRESHOLD_RST;
         base_ff      <= '0;
         next_ff      <= '0;
         phy_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         phy_ff       <= phy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW_LIMIT:    limit_ff  <= csr_wdata[LIMIT_W-1:0];
               CSR_QUEUE_THRESHOLD: thresh_ff <= csr_wdata[QLEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff    <= req_tuser;
         handle_ff  <= req_tdata[7:0];
         rxack_ff   <= req_tdata[15:8];
         hasdata_ff <= req_tdata[16];
         lexp_ff    <= req_tdata[24:17];
         qlen_ff    <= req_tdata[34:25];
      end
      w_ff      <= w_in;
      room_ff   <= room_in;
      moved_ff  <= moved_in;
      acc_ff    <= acc_in;
      seq_ff    <= seq_in;
      en_ff     <= en_in;
      busy_ff   <= busy_in;
      s_ff      <= s_in;
      n_ff      <= n_in;
      lastrs_ff <= lastrs_in;
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   logic [SEQ_W-1:0] outst_chk, rel_chk;
   assign outst_chk = next_ff - base_ff;
   assign rel_chk   = rsp_data_ff.frame_seq - base_ff;

   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      outst_chk <= SEQ_W'(WINDOW_MAX))
      else $error("outstanding frames exceed window maximum");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("ready asserted while an event is in progress");

   a_store_write_room: assert property (@(posedge clock) disable iff (reset)
      scmd.wr_en |-> (room_ff && outst_chk < SEQ_W'(WINDOW_MAX)))
      else $error("store written with a full window");

   a_resend_in_window: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RD || state_ff == ST_RESEND) && rsp_valid_ff &&
       rsp_data_ff.frame_valid && !rsp_user_ff && !rsp_data_ff.accepted)
      |-> (rel_chk < outst_chk))
      else $error("resent frame outside the window");

endmodule
`default_nettype wire

// ===== sv/gbn_dist_unit.sv =====
// Shared modulo sequence distance and bound compare unit.
`default_nettype none
module gbn_dist_unit
   import gbn_pkg::*;
(
   input  dist_req_type req,
   output dist_rsp_type rsp
);

   logic [SEQ_W-1:0] diff;

   assign diff      = req.a - req.b;
   assign rsp.diff  = diff;
   assign rsp.below = {1'b0, diff} < req.bound;

endmodule
`default_nettype wire

// ===== sv/gbn_store.sv =====
// Handle and piggyback ack store, one slot per sequence number.
`default_nettype none
module gbn_store
   import gbn_pkg::*;
(
   input  logic          clock,
   input  store_cmd_type cmd,
   output slot_type      rd_data
);

   slot_type mem [BUFFER_SLOTS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
